FILE: hw/rtl/mmte_pkg.sv
package mmte_pkg;

  // Default sizes
  localparam int NUM_EFFECTS_DEF    = 32;
  localparam int MAX_BYTES_DEF      = 16;
  localparam int CHECKSUM_START_DEF = 5;

  // Queue depths
  localparam int CMD_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 4;

  // Input action codes
  localparam logic [1:0] ACT_WRITE_WORD   = 2'd0;
  localparam logic [1:0] ACT_WRITE_LENGTH = 2'd1;
  localparam logic [1:0] ACT_GENERATE     = 2'd2;

  // Template word kinds, bits 9:8
  localparam logic [1:0] KIND_LITERAL  = 2'd0;
  localparam logic [1:0] KIND_CHANNEL  = 2'd1;
  localparam logic [1:0] KIND_VALUE    = 2'd2;
  localparam logic [1:0] KIND_CHECKSUM = 2'd3;

  typedef enum logic [1:0] {
    CMD_WORD,
    CMD_LENGTH,
    CMD_GENERATE
  } cmd_kind_t;

  // Command queued from front to back; length is already saturated.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [4:0]  effect;
    logic [3:0]  position;
    logic [9:0]  word;
    logic [4:0]  length;
    logic [3:0]  channel;
    logic [7:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] position;
    logic       last;
  } result_t;

endpackage

FILE: hw/rtl/mmte_fifo.sv
module mmte_fifo import mmte_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  output logic                           full,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/mmte_front.sv
module mmte_front import mmte_pkg::*; #(
  parameter int NUM_EFFECTS = NUM_EFFECTS_DEF,
  parameter int MAX_BYTES   = MAX_BYTES_DEF
) (
  input  logic [1:0] action,
  input  logic [4:0] effect_index,
  input  logic [3:0] word_position,
  input  logic [9:0] template_word,
  input  logic [4:0] template_length,
  input  logic [3:0] channel,
  input  logic [7:0] value,
  output cmd_t       cmd,
  output logic       keep
);

  logic       eff_ok;
  logic       pos_ok;
  logic [4:0] len_sat;

  assign eff_ok  = 32'(effect_index) < 32'(NUM_EFFECTS);
  assign pos_ok  = 32'(word_position) < 32'(MAX_BYTES);
  assign len_sat = (32'(template_length) > 32'(MAX_BYTES)) ? 5'(MAX_BYTES) : template_length;

  always_comb begin
    cmd.effect   = effect_index;
    cmd.position = word_position;
    cmd.word     = template_word;
    cmd.length   = len_sat;
    cmd.channel  = channel;
    cmd.value    = value;
    case (action)
      ACT_WRITE_WORD: begin
        cmd.kind = CMD_WORD;
        keep     = eff_ok && pos_ok;
      end
      ACT_WRITE_LENGTH: begin
        cmd.kind = CMD_LENGTH;
        keep     = eff_ok;
      end
      ACT_GENERATE: begin
        cmd.kind = CMD_GENERATE;
        keep     = eff_ok;
      end
      default: begin
        // unused action: dropped
        cmd.kind = CMD_WORD;
        keep     = 1'b0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mmte_back.sv
module mmte_back import mmte_pkg::*; #(
  parameter int NUM_EFFECTS    = NUM_EFFECTS_DEF,
  parameter int MAX_BYTES      = MAX_BYTES_DEF,
  parameter int CHECKSUM_START = CHECKSUM_START_DEF,
  parameter int OUT_DEPTH      = OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  input  logic                           cmd_empty,
  output logic                           cmd_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_push,
  output result_t                        res
);

  localparam int EFF_W  = (NUM_EFFECTS > 1) ? $clog2(NUM_EFFECTS) : 1;
  localparam int LEN_W  = $clog2(MAX_BYTES + 1);
  localparam int TDEPTH = NUM_EFFECTS * MAX_BYTES;
  localparam int AW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LEN  = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [9:0]       tmem [TDEPTH];
  logic [LEN_W-1:0] lmem [NUM_EFFECTS];
  logic [NUM_EFFECTS-1:0] lvalid;

  logic [9:0]       tword;
  logic [LEN_W-1:0] lword;
  logic             lword_valid;

  logic [AW-1:0]    base;
  logic [LEN_W-1:0] issue_idx;
  logic [LEN_W-1:0] emit_idx;
  logic [LEN_W-1:0] nbytes;
  logic [LEN_W-1:0] len_rd;
  logic             pend;
  logic [6:0]       sum;
  logic [3:0]       chan;
  logic [7:0]       val;

  logic             take;
  logic             we_word;
  logic             we_len;
  logic             rd_len;
  logic             room;
  logic             issue;
  logic             is_last;
  logic             in_sum;
  logic [7:0]       byte_out;
  logic [EFF_W-1:0] eff;

  assign eff      = EFF_W'(cmd.effect);
  assign take     = (state == S_IDLE) && !cmd_empty;
  assign cmd_pop  = take;
  assign we_word  = take && (cmd.kind == CMD_WORD);
  assign we_len   = take && (cmd.kind == CMD_LENGTH);
  assign rd_len   = take && (cmd.kind == CMD_GENERATE);
  assign len_rd   = lword_valid ? lword : '0;

  // Count the word in flight so the result queue never overflows.
  assign room     = (32'(out_count) + 32'(pend)) < 32'(OUT_DEPTH);
  assign issue    = (state == S_RUN) && (issue_idx != nbytes) && room;
  assign is_last  = (emit_idx == nbytes - 1'b1);
  assign in_sum   = 32'(emit_idx) >= 32'(CHECKSUM_START);

  always_comb begin
    case (tword[9:8])
      KIND_LITERAL:  byte_out = tword[7:0];
      KIND_CHANNEL:  byte_out = tword[7:0] | {4'b0, chan};
      KIND_VALUE:    byte_out = val;
      KIND_CHECKSUM: byte_out = {1'b0, 7'(~sum + 7'd1)};
      default:       byte_out = tword[7:0];
    endcase
  end

  assign res_push     = (state == S_RUN) && pend;
  assign res.data     = byte_out;
  assign res.position = 4'(emit_idx);
  assign res.last     = is_last;

  // Memories
  always_ff @(posedge clk) begin
    if (we_word) begin
      tmem[AW'(32'(cmd.effect) * MAX_BYTES + 32'(cmd.position))] <= cmd.word;
    end
    if (issue) begin
      tword <= tmem[base + AW'(issue_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (we_len) begin
      lmem[eff] <= LEN_W'(cmd.length);
    end
    if (rd_len) begin
      lword       <= lmem[eff];
      lword_valid <= lvalid[eff];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (rd_len) state_next = S_LEN;
      S_LEN:  state_next = (len_rd == '0) ? S_IDLE : S_RUN;
      S_RUN:  if (pend && is_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend   <= 1'b0;
      lvalid <= '0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (we_len) begin
        lvalid[eff] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_len) begin
      base <= AW'(32'(cmd.effect) * MAX_BYTES);
      chan <= cmd.channel;
      val  <= cmd.value;
    end
    if (state == S_LEN) begin
      nbytes    <= len_rd;
      issue_idx <= '0;
      emit_idx  <= '0;
      sum       <= '0;
    end else begin
      if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (res_push) begin
        emit_idx <= emit_idx + 1'b1;
        if (in_sum) begin
          sum <= sum + byte_out[6:0];
        end
      end
    end
  end

endmodule

FILE: hw/rtl/midi_message_template_expander.sv
// MIDI message template expander. Holds one message template per effect (a
// length and up to MAX_BYTES 10-bit words) and expands a generate transaction
// into message bytes, one result transaction per byte, with out_position and
// a last flag on the final byte. Word bits 9:8 pick the byte: literal,
// literal ORed with the channel, the value, or a checksum over the bytes
// emitted from CHECKSUM_START onward, (128 - sum mod 128) & 0x7F. Write
// transactions are taken while idle and emit nothing. A generate is taken
// while idle, reading its length, which the length state then loads; the
// run state issues one template read per byte, limited by the single read
// port of the template memory, while the result queue has room; each read
// word is registered before its byte enters the result queue. Zero-length
// effects, unused actions and out-of-range effects or positions produce no
// output. Templates read before being written give undefined bytes; lengths
// reset to zero. A zero-length generate returns to idle from S_LEN.
module midi_message_template_expander import mmte_pkg::*; #(
  parameter int NUM_EFFECTS    = NUM_EFFECTS_DEF,
  parameter int MAX_BYTES      = MAX_BYTES_DEF,
  parameter int CHECKSUM_START = CHECKSUM_START_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input queue side
  input  logic       push,
  output logic       full,
  input  logic [1:0] action,
  input  logic [4:0] effect_index,
  input  logic [3:0] word_position,
  input  logic [9:0] template_word,
  input  logic [4:0] template_length,
  input  logic [3:0] channel,
  input  logic [7:0] value,
  // result queue side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [3:0] out_position,
  output logic       last
);

  localparam int CMD_W  = $bits(cmd_t);
  localparam int RES_W  = $bits(result_t);
  localparam int OCNT_W = $clog2(OUT_DEPTH_DEF + 1);
  localparam int CCNT_W = $clog2(CMD_DEPTH_DEF + 1);

  cmd_t              front_cmd;
  logic              front_keep;
  cmd_t              back_cmd;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [CCNT_W-1:0] cmd_count;
  logic              res_push;
  result_t           res_in;
  result_t           res_out;
  logic              res_full;
  logic [OCNT_W-1:0] res_count;

  // Front: range checks, length saturation, dropping of no-op transactions.
  mmte_front #(
    .NUM_EFFECTS (NUM_EFFECTS),
    .MAX_BYTES   (MAX_BYTES)
  ) u_front (
    .action          (action),
    .effect_index    (effect_index),
    .word_position   (word_position),
    .template_word   (template_word),
    .template_length (template_length),
    .channel         (channel),
    .value           (value),
    .cmd             (front_cmd),
    .keep            (front_keep)
  );

  // Command queue decouples input acceptance from message expansion;
  // an accepted transaction that is dropped simply never enters it.
  mmte_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH_DEF)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !full && front_keep),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty),
    .count (cmd_count)
  );

  // Back: template and length memories, byte sequencer, checksum.
  mmte_back #(
    .NUM_EFFECTS    (NUM_EFFECTS),
    .MAX_BYTES      (MAX_BYTES),
    .CHECKSUM_START (CHECKSUM_START),
    .OUT_DEPTH      (OUT_DEPTH_DEF)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_count (res_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue; the back end only issues reads it has room for.
  mmte_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH_DEF)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty),
    .count (res_count)
  );

  assign out_byte     = res_out.data;
  assign out_position = res_out.position;
  assign last         = res_out.last;

endmodule

FILE: hw/rtl/mmte_checker.sv
module mmte_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [3:0] out_position,
  input logic       last
);

  // Expected position of the next result byte.
  logic [3:0] exp_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= '0;
    end else if (pop && !empty) begin
      exp_pos <= last ? 4'd0 : out_position + 4'd1;
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_position)
                          && $stable(last)))
    else $error("waiting result changed");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_position == exp_pos))
    else $error("result position out of sequence");

endmodule

bind midi_message_template_expander mmte_checker u_mmte_checker (.*);

FILE: test/message_checker.sv
module message_checker import mmte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [1:0] action,
  input  logic [4:0] effect_index,
  input  logic [3:0] word_position,
  input  logic [9:0] template_word,
  input  logic [4:0] template_length,
  input  logic [3:0] channel,
  input  logic [7:0] value,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic [3:0] out_position,
  input  logic       last,
  output int         mismatches,
  output int         bytes_due
);

  logic [9:0] tmpl [NUM_EFFECTS_DEF][MAX_BYTES_DEF];
  logic [4:0] tmpl_len [NUM_EFFECTS_DEF];
  result_t    expected_bytes [$];
  result_t    got;
  result_t    want;

  // Expand one generate transaction into its message bytes.
  task automatic expand_message(input logic [4:0] eff, input logic [3:0] chan,
                                input logic [7:0] val);
    logic [6:0] sum;
    logic [9:0] w;
    result_t    r;
    int         i;
    sum = '0;
    for (i = 0; i < tmpl_len[eff]; i++) begin
      w = tmpl[eff][i];
      case (w[9:8])
        KIND_LITERAL:  r.data = w[7:0];
        KIND_CHANNEL:  r.data = w[7:0] | {4'h0, chan};
        KIND_VALUE:    r.data = val;
        KIND_CHECKSUM: r.data = {1'b0, ~sum + 7'd1};
        default:       r.data = w[7:0];
      endcase
      if (i >= CHECKSUM_START_DEF) sum = sum + r.data[6:0];
      r.position = i[3:0];
      r.last     = (i == tmpl_len[eff] - 1);
      expected_bytes.push_back(r);
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      foreach (tmpl_len[e]) tmpl_len[e] = '0;
      expected_bytes.delete();
    end else begin
      if (pop && !empty) begin
        got = '{data: out_byte, position: out_position, last: last};
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected byte %h pos %0d last %0b",
                     $time, got.data, got.position, got.last);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch, expected byte %h pos %0d last %0b, got %h pos %0d last %0b",
                       $time, want.data, want.position, want.last,
                       got.data, got.position, got.last);
          end
        end
      end
      if (push && !full) begin
        case (action)
          ACT_WRITE_WORD:   tmpl[effect_index][word_position] = template_word;
          ACT_WRITE_LENGTH: tmpl_len[effect_index] = (template_length > MAX_BYTES_DEF) ?
                              5'(MAX_BYTES_DEF) : template_length;
          ACT_GENERATE:     expand_message(effect_index, channel, value);
          default: ;
        endcase
      end
    end
    bytes_due <= expected_bytes.size();
  end

endmodule

FILE: test/tb.sv
module tb;
  import mmte_pkg::*;

  // action code the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] action;
  logic [4:0] effect_index;
  logic [3:0] word_position;
  logic [9:0] template_word;
  logic [4:0] template_length;
  logic [3:0] channel;
  logic [7:0] value;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic [3:0] out_position;
  logic       last;

  int mismatches;
  int bytes_due;

  // idling knobs, in percent of cycles
  int idle_pct;
  int stall_pct;

  // long receiver hold-off, run by its own process
  bit   hold_req;
  logic hold_pop;

  // stimulus bookkeeping: which template words were ever written, and the
  // saturated length per effect, so a generate never reads an unwritten word
  logic [15:0] word_seen [NUM_EFFECTS_DEF];
  logic [4:0]  len_seen  [NUM_EFFECTS_DEF];
  int          counted;  // non-ignored transactions accepted

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  midi_message_template_expander dut (.*);
  message_checker chk (.*);

  // Offer one transaction; returns at the edge where it was accepted.
  // push is only lowered during an idle gap, never lowered and raised in
  // the same step.
  task automatic issue(input logic [1:0] a, input logic [4:0] e, input logic [3:0] p,
                       input logic [9:0] w, input logic [4:0] n, input logic [3:0] c,
                       input logic [7:0] v);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    action          <= a;
    effect_index    <= e;
    word_position   <= p;
    template_word   <= w;
    template_length <= n;
    channel         <= c;
    value           <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    if (a == ACT_WRITE_WORD) word_seen[e][p] = 1'b1;
    else if (a == ACT_WRITE_LENGTH) len_seen[e] = (n > MAX_BYTES_DEF) ? 5'(MAX_BYTES_DEF) : n;
    if (a != ACT_UNUSED) counted++;
  endtask

  // Sender pause: nothing offered until every expected byte has come out.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
  endtask

  function automatic bit can_expand(input int e);
    logic [16:0] need;
    need = (17'd1 << len_seen[e]) - 17'd1;
    return (word_seen[e] & need[15:0]) == need[15:0];
  endfunction

  // Fill words 0..n-1 of an effect with random kinds and literals, then set
  // its length; a full template sometimes gets an oversized length to
  // exercise saturation.
  task automatic load_template(input int e, input int n);
    int p;
    logic [4:0] len;
    for (p = 0; p < n; p++)
      issue(ACT_WRITE_WORD, 5'(e), 4'(p), 10'($urandom), 5'($urandom), 4'($urandom),
            8'($urandom));
    len = 5'(n);
    if (n == MAX_BYTES_DEF && $urandom_range(1)) len = 5'($urandom_range(16, 31));
    issue(ACT_WRITE_LENGTH, 5'(e), 4'($urandom), 10'($urandom), len, 4'($urandom),
          8'($urandom));
  endtask

  task automatic gen(input int e);
    issue(ACT_GENERATE, 5'(e), 4'($urandom), 10'($urandom), 5'($urandom), 4'($urandom),
          8'($urandom));
  endtask

  // One random step: mostly well-formed load/generate traffic, some noise.
  task automatic random_step();
    int r;
    int e;
    int tries;
    bit found;
    r = $urandom_range(99);
    if (r < 20) begin
      e = $urandom_range(NUM_EFFECTS_DEF - 1);
      load_template(e, $urandom_range(1, MAX_BYTES_DEF));
      repeat ($urandom_range(1, 3)) gen(e);
    end else if (r < 70) begin
      found = 1'b0;
      for (tries = 0; tries < 8 && !found; tries++) begin
        e = $urandom_range(NUM_EFFECTS_DEF - 1);
        found = can_expand(e) && len_seen[e] != 0;
      end
      if (found) gen(e);
      else load_template(e, $urandom_range(1, MAX_BYTES_DEF));
    end else if (r < 80) begin
      // stray word write, may overwrite a live template
      issue(ACT_WRITE_WORD, 5'($urandom), 4'($urandom), 10'($urandom), 5'($urandom),
            4'($urandom), 8'($urandom));
    end else if (r < 88) begin
      // stray length write, 0..31; may leave an effect not expandable
      issue(ACT_WRITE_LENGTH, 5'($urandom), 4'($urandom), 10'($urandom), 5'($urandom),
            4'($urandom), 8'($urandom));
    end else if (r < 94) begin
      e = $urandom_range(NUM_EFFECTS_DEF - 1);
      if (can_expand(e)) gen(e);  // includes zero-length effects
      else issue(ACT_UNUSED, 5'(e), 4'($urandom), 10'($urandom), 5'($urandom),
                 4'($urandom), 8'($urandom));
    end else begin
      issue(ACT_UNUSED, 5'($urandom), 4'($urandom), 10'($urandom), 5'($urandom),
            4'($urandom), 8'($urandom));
    end
  endtask

  // Receiver: pops every cycle unless stalling or held off.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      pop <= !hold_pop && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long hold-off so the block backs up and raises full.
  initial begin
    hold_pop <= 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold_pop <= 1'b1;
    repeat (300) @(posedge clk);
    hold_pop <= 1'b0;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [9:0] demo [MAX_BYTES_DEF];
    int p;
    int ph;
    int target;

    rst             <= 1'b1;
    push            <= 1'b0;
    action          <= ACT_WRITE_WORD;
    effect_index    <= '0;
    word_position   <= '0;
    template_word   <= '0;
    template_length <= '0;
    channel         <= '0;
    value           <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    counted = 0;
    foreach (word_seen[e]) begin
      word_seen[e] = '0;
      len_seen[e]  = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // zero-length effect straight out of reset: no bytes
    issue(ACT_GENERATE, 5'd0, 4'd0, 10'd0, 5'd0, 4'd0, 8'd0);
    // unused action code with every field at its top value: ignored
    issue(ACT_UNUSED, 5'h1F, 4'hF, 10'h3FF, 5'h1F, 4'hF, 8'hFF);

    // full 16-word template on the top effect: early checksums (before and
    // at the checksum start) give zero, later ones include earlier checksum
    // bytes; extremes of the word field included
    demo = '{{KIND_LITERAL, 8'hF0}, {KIND_CHANNEL, 8'h90}, {KIND_VALUE, 8'h00},
             {KIND_CHECKSUM, 8'h00}, 10'h3FF, {KIND_CHECKSUM, 8'h00},
             {KIND_VALUE, 8'hA5}, {KIND_LITERAL, 8'hFF}, {KIND_CHECKSUM, 8'h12},
             {KIND_CHANNEL, 8'h00}, {KIND_CHECKSUM, 8'h00}, 10'h000,
             {KIND_CHANNEL, 8'hFF}, {KIND_VALUE, 8'h7F}, {KIND_LITERAL, 8'hF7},
             {KIND_CHECKSUM, 8'h80}};
    for (p = 0; p < MAX_BYTES_DEF; p++)
      issue(ACT_WRITE_WORD, 5'd31, 4'(p), demo[p], 5'($urandom), 4'($urandom),
            8'($urandom));
    // oversized length saturates to 16
    issue(ACT_WRITE_LENGTH, 5'd31, 4'd0, 10'd0, 5'd31, 4'd0, 8'd0);
    issue(ACT_GENERATE, 5'd31, 4'd0, 10'd0, 5'd0, 4'hF, 8'hFF);
    issue(ACT_GENERATE, 5'd31, 4'hF, 10'h3FF, 5'h1F, 4'h0, 8'h00);
    // length back to zero: nothing comes out
    issue(ACT_WRITE_LENGTH, 5'd31, 4'd0, 10'd0, 5'd0, 4'd0, 8'd0);
    issue(ACT_GENERATE, 5'd31, 4'd0, 10'd0, 5'd0, 4'd7, 8'h11);
    // single-byte message: last on position 0
    issue(ACT_WRITE_LENGTH, 5'd31, 4'd0, 10'd0, 5'd1, 4'd0, 8'd0);
    issue(ACT_GENERATE, 5'd31, 4'd0, 10'd0, 5'd0, 4'd5, 8'h3C);

    // --- back-pressure: receiver held off while the sender keeps going ---
    hold_req = 1'b1;
    load_template(3, MAX_BYTES_DEF);
    repeat (10) gen(3);
    drain();

    // --- random part, four idling phases ---
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      target = counted + 40;
      while (counted < target) random_step();
      drain();
    end

    // quiet tail to catch any stray byte
    repeat (40) @(posedge clk);
    if (mismatches == 0 && bytes_due == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
